### rtl/htlp_pkg.sv
// htlp_pkg: shared types and codes for the linear-probe hash table
// no dependencies
package htlp_pkg;
	typedef enum logic [1:0] {
		TAG_NEVER = 2'd0,
		TAG_OCC   = 2'd1,
		TAG_TOMB  = 2'd2
	} tag_t;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_REMOVED  = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_FOUND    = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] key;
		logic [31:0] payload;
	} cmd_t;
endpackage

### rtl/htlp_front.sv
// htlp_front: accepts transactions into a two-entry queue
// depends on htlp_pkg
module htlp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  htlp_pkg::cmd_t in_cmd,
	output logic           q_valid,
	input  logic           q_ready,
	output htlp_pkg::cmd_t q_cmd
);
	htlp_pkg::cmd_t buf_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) buf_q[wr_q] <= in_cmd;
	end
endmodule

### rtl/htlp_back.sv
// htlp_back: probe sequencer over the slot memories, clearing pass and result register
// depends on htlp_pkg
module htlp_back #(
	parameter int TABLE_SIZE = 1021
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  htlp_pkg::cmd_t q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     status,
	output logic           found,
	output logic [9:0]     slot,
	output logic [31:0]    data_out,
	output logic [9:0]     occupancy
);
	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);
	localparam logic [CW-1:0] FULLC = CW'(TABLE_SIZE);
	localparam logic [30:0] RED = 31'((2 ** AW) % TABLE_SIZE);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_READ, S_CHECK, S_DONE} state_t;

	logic [1:0]  tag_mem [TABLE_SIZE];
	logic [30:0] key_mem [TABLE_SIZE];
	logic [31:0] pay_mem [TABLE_SIZE];

	state_t         state_q;
	htlp_pkg::cmd_t cmd_q;
	logic [30:0]    rem_q;
	logic [AW-1:0]  idx_q, vac_q, hit_idx_q;
	logic           vac_ok_q, hit_q;
	logic [CW-1:0]  n_q, occ_q;
	logic [1:0]     tag_rd;
	logic [30:0]    key_rd;
	logic [31:0]    pay_rd;
	logic           rd_en, wr_en, pw_en;
	logic [AW-1:0]  wr_addr;
	logic [1:0]     wr_tag;
	logic [30:0]    fold_hi, fold;
	logic [AW-1:0]  nxt;
	logic           stop, is_hit, last_probe;

	assign q_ready = (state_q == S_IDLE);
	assign fold_hi = rem_q >> AW;
	assign fold    = 31'(fold_hi * RED) + {{(31 - AW){1'b0}}, rem_q[AW-1:0]};
	assign nxt     = (idx_q == LAST) ? '0 : idx_q + AW'(1);
	assign is_hit  = (tag_rd == htlp_pkg::TAG_OCC) && (key_rd == cmd_q.key);
	assign stop    = (tag_rd == htlp_pkg::TAG_NEVER) || is_hit;
	assign last_probe = (n_q == FULLC - CW'(1));
	assign rd_en   = (state_q == S_READ);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd <= tag_mem[idx_q];
			key_rd <= key_mem[idx_q];
			pay_rd <= pay_mem[idx_q];
		end
		if (wr_en) tag_mem[wr_addr] <= wr_tag;
		if (pw_en) pay_mem[wr_addr] <= cmd_q.payload;
		if (pw_en && wr_tag == htlp_pkg::TAG_OCC) key_mem[wr_addr] <= cmd_q.key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			idx_q     <= '0;
			occ_q     <= '0;
			out_valid <= 1'b0;
			wr_en     <= 1'b0;
			pw_en     <= 1'b0;
			wr_addr   <= '0;
			wr_tag    <= htlp_pkg::TAG_NEVER;
		end else begin
			wr_en <= 1'b0;
			pw_en <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					wr_en   <= 1'b1;
					wr_addr <= idx_q;
					wr_tag  <= htlp_pkg::TAG_NEVER;
					idx_q   <= nxt;
					if (idx_q == LAST) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						cmd_q    <= q_cmd;
						rem_q    <= q_cmd.key;
						hit_q    <= 1'b0;
						vac_ok_q <= 1'b0;
						n_q      <= '0;
						state_q  <= S_MOD;
					end
				end
				S_MOD: begin
					// fold the high bits back in by 2**AW mod table size, then one subtract
					if (fold_hi != '0) begin
						rem_q <= fold;
					end else begin
						if (rem_q >= 31'(TABLE_SIZE))
							idx_q <= AW'(rem_q - 31'(TABLE_SIZE));
						else
							idx_q <= AW'(rem_q);
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!vac_ok_q && tag_rd != htlp_pkg::TAG_OCC) begin
						vac_ok_q <= 1'b1;
						vac_q    <= idx_q;
					end
					if (is_hit) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (stop || last_probe) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= nxt;
						n_q     <= n_q + CW'(1);
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						found     <= hit_q;
						slot      <= '0;
						data_out  <= '0;
						state_q   <= S_IDLE;
						if (cmd_q.kind == htlp_pkg::KIND_INSERT) begin
							if (hit_q) begin
								status  <= htlp_pkg::ST_UPDATED;
								slot    <= 10'(hit_idx_q);
								pw_en   <= 1'b1;
								wr_addr <= hit_idx_q;
								wr_tag  <= htlp_pkg::TAG_TOMB;
								occupancy <= 10'(occ_q);
							end else if (occ_q >= FULLC || !vac_ok_q) begin
								status  <= htlp_pkg::ST_FULL;
								occupancy <= 10'(occ_q);
							end else begin
								status  <= htlp_pkg::ST_INSERTED;
								slot    <= 10'(vac_q);
								wr_en   <= 1'b1;
								pw_en   <= 1'b1;
								wr_addr <= vac_q;
								wr_tag  <= htlp_pkg::TAG_OCC;
								occ_q   <= occ_q + CW'(1);
								occupancy <= 10'(occ_q + CW'(1));
							end
						end else if (cmd_q.kind == htlp_pkg::KIND_REMOVE) begin
							if (hit_q) begin
								status  <= htlp_pkg::ST_REMOVED;
								slot    <= 10'(hit_idx_q);
								wr_en   <= 1'b1;
								wr_addr <= hit_idx_q;
								wr_tag  <= htlp_pkg::TAG_TOMB;
								occ_q   <= occ_q - CW'(1);
								occupancy <= 10'(occ_q - CW'(1));
							end else begin
								status  <= htlp_pkg::ST_NOTFOUND;
								occupancy <= 10'(occ_q);
							end
						end else begin
							occupancy <= 10'(occ_q);
							if (hit_q) begin
								status   <= htlp_pkg::ST_FOUND;
								slot     <= 10'(hit_idx_q);
								data_out <= pay_rd;
							end else begin
								status <= htlp_pkg::ST_NOTFOUND;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/hash_table_linear_probe.sv
// hash_table_linear_probe: top level, front queue feeding the probe engine
// depends on htlp_pkg, htlp_front, htlp_back
//
// channel  direction  handshake                payload
// in       input      in_valid / in_ready      kind, key, payload
// out      output     out_valid / out_ready    status, found, slot, data_out, occupancy
//
// a transaction enters the engine, its key is folded modulo the table size, the slots
// are probed one at a time through the single read port of the slot memories (each one
// read, then checked), and the engine answers before it takes the next transaction
// after reset a clearing pass marks every slot never-used before the first transaction
// the two-entry front queue keeps accepting while it has room, also while the engine works or the result stalls
module hash_table_linear_probe #(
	parameter int TABLE_SIZE = 1021
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [30:0] key,
	input  logic [31:0] payload,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        found,
	output logic [9:0]  slot,
	output logic [31:0] data_out,
	output logic [9:0]  occupancy
);
	htlp_pkg::cmd_t in_cmd, q_cmd;
	logic           q_valid, q_ready;

	assign in_cmd = '{kind: kind, key: key, payload: payload};

	htlp_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	htlp_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.out_valid, .out_ready, .status, .found, .slot, .data_out, .occupancy
	);
endmodule
